// ===== rtl/cpu_bus_decoder_with_oam_dma_core_macros.svh =====
// assertion macros for the bus decoder
`ifndef CPU_BUS_DECODER_WITH_OAM_DMA_CORE_MACROS_SVH
`define CPU_BUS_DECODER_WITH_OAM_DMA_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CBD_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");
`define CBD_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define CBD_ASSERT_IMP(label, clk, rst_n, pre, post)
`define CBD_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/cbdoam_pkg.sv =====
`default_nettype none
package cbdoam_pkg;

  localparam int unsigned RAM_ADDR_BITS = 11;
  localparam int unsigned RAM_DEPTH = 1 << RAM_ADDR_BITS;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    TGT_OPEN = 3'd0,
    TGT_CART = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_PPU  = 3'd3,
    TGT_DMA  = 3'd4,
    TGT_CTRL = 3'd5
  } target_t;

  localparam logic [15:0] PPU_BASE    = 16'h2000;
  localparam logic [15:0] IO_BASE     = 16'h4000;
  localparam logic [15:0] DMA_TRIGGER = 16'h4014;
  localparam logic [15:0] CTRL_PORT0  = 16'h4016;
  localparam logic [15:0] CTRL_PORT1  = 16'h4017;

  localparam logic [2:0] PHASE_EVEN_SLOT = 3'd0;
  localparam logic [2:0] PHASE_ODD_SLOT  = 3'd3;
  localparam logic [2:0] PHASE_LAST      = 3'd5;

  typedef struct packed {
    target_t    target;
    logic       from_ram;
    logic [7:0] data;
    logic       port;
  } rd_dec_t;

  function automatic rd_dec_t read_decode(logic [15:0] addr, logic claim, logic [7:0] ext);
    rd_dec_t d;
    d.target   = TGT_OPEN;
    d.from_ram = 1'b0;
    d.data     = 8'h00;
    d.port     = 1'b0;
    if (claim) begin
      d.target = TGT_CART;
      d.data   = ext;
    end else if (addr < PPU_BASE) begin
      d.target   = TGT_RAM;
      d.from_ram = 1'b1;
    end else if (addr < IO_BASE) begin
      d.target = TGT_PPU;
      d.data   = ext;
    end else if (addr == CTRL_PORT0 || addr == CTRL_PORT1) begin
      d.target = TGT_CTRL;
      d.data   = ext;
      d.port   = addr[0];
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cbdoam_ram.sv =====
`default_nettype none
module cbdoam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpu_bus_decoder_with_oam_dma_core.sv =====
// CPU bus decoder with sprite DMA. Each request is a cpu read, a cpu write, a system tick
// or no action, and each gives exactly one result. The block takes one request per clock;
// the work RAM is a synchronous memory whose registered read data drives the read data
// output directly, so a request's result is offered the cycle after it is accepted, and a
// new request is taken whenever the result register is empty or being drained in that same
// cycle. After reset the work RAM is cleared one entry a clock, all 2**RAM_ADDR_BITS entries
// (2048 at the default size), and in_ready stays low until that pass is done. A DMA
// source byte read from work RAM is latched from the RAM's registered read data.
`default_nettype none
`include "cpu_bus_decoder_with_oam_dma_core_macros.svh"
module cpu_bus_decoder_with_oam_dma_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_cart_claims,
  input  wire logic [7:0]  in_external_read_data,
  input  wire logic [7:0]  in_oam_pointer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_target,
  output logic [7:0]       out_read_data,
  output logic             out_controller_port,
  output logic             out_oam_write_valid,
  output logic [7:0]       out_oam_write_addr,
  output logic [7:0]       out_oam_write_data,
  output logic             out_cpu_clock_enable,
  output logic             out_dma_busy,
  output logic [15:0]      out_dma_source_addr
);
  import cbdoam_pkg::*;

  logic                     clr_active_r, clr_active_nxt;
  logic [RAM_ADDR_BITS-1:0] clr_addr_r, clr_addr_nxt;

  logic [2:0] tick_phase_r, tick_phase_nxt;
  logic       dma_active_r, dma_active_nxt;
  logic       dma_align_r, dma_align_nxt;
  logic [7:0] dma_page_r, dma_page_nxt;
  logic [7:0] dma_offset_r, dma_offset_nxt;
  logic [7:0] dma_done_r, dma_done_nxt;
  logic [7:0] dma_latched_r, dma_latched_nxt;
  logic       latch_pend_r, latch_pend_nxt;

  logic       out_valid_r, out_valid_nxt;
  target_t    tgt_r, tgt_nxt;
  logic [7:0] rdata_r, rdata_nxt;
  logic       from_ram_r, from_ram_nxt;
  logic       port_r, port_nxt;
  logic       owv_r, owv_nxt;
  logic [7:0] owa_r, owa_nxt;
  logic [7:0] owd_r, owd_nxt;
  logic       cen_r, cen_nxt;

  logic                     ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_wa;
  logic [7:0]               ram_wd;
  logic                     ram_re;
  logic [RAM_ADDR_BITS-1:0] ram_ra;
  logic [7:0]               ram_q;

  logic       accept;
  logic [15:0] src_addr;
  rd_dec_t    rdec;
  rd_dec_t    sdec;
  logic [7:0] done_inc;

  assign in_ready = !clr_active_r && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign src_addr = {dma_page_r, dma_offset_r};
  assign rdec     = read_decode(in_address, in_cart_claims, in_external_read_data);
  assign sdec     = read_decode(src_addr, in_cart_claims, in_external_read_data);
  assign done_inc = dma_done_r + 8'd1;

  cbdoam_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_work_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_wa),
    .wdata(ram_wd),
    .re   (ram_re),
    .raddr(ram_ra),
    .rdata(ram_q)
  );

  // clearing pass
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + RAM_ADDR_BITS'(1);
      if (&clr_addr_r) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  // request decode and dma sequencing
  always_comb begin
    tick_phase_nxt  = tick_phase_r;
    dma_active_nxt  = dma_active_r;
    dma_align_nxt   = dma_align_r;
    dma_page_nxt    = dma_page_r;
    dma_offset_nxt  = dma_offset_r;
    dma_done_nxt    = dma_done_r;
    dma_latched_nxt = dma_latched_r;
    latch_pend_nxt  = 1'b0;

    tgt_nxt      = TGT_OPEN;
    rdata_nxt    = 8'h00;
    from_ram_nxt = 1'b0;
    port_nxt     = 1'b0;
    owv_nxt      = 1'b0;
    owa_nxt      = 8'h00;
    owd_nxt      = 8'h00;
    cen_nxt      = 1'b0;

    ram_we = clr_active_r;
    ram_wa = clr_addr_r;
    ram_wd = 8'h00;
    ram_re = 1'b0;
    ram_ra = in_address[RAM_ADDR_BITS-1:0];

    if (latch_pend_r) begin
      dma_latched_nxt = ram_q;
    end

    if (accept) begin
      unique case (action_t'(in_action))
        ACT_WRITE: begin
          if (in_cart_claims) begin
            tgt_nxt = TGT_CART;
          end else if (in_address < PPU_BASE) begin
            ram_we  = 1'b1;
            ram_wa  = in_address[RAM_ADDR_BITS-1:0];
            ram_wd  = in_write_data;
            tgt_nxt = TGT_RAM;
          end else if (in_address < IO_BASE) begin
            tgt_nxt = TGT_PPU;
          end else if (in_address == DMA_TRIGGER) begin
            dma_page_nxt   = in_write_data;
            dma_offset_nxt = in_oam_pointer;
            dma_done_nxt   = 8'h00;
            dma_active_nxt = 1'b1;
            tgt_nxt        = TGT_DMA;
          end else if (in_address == CTRL_PORT0 || in_address == CTRL_PORT1) begin
            tgt_nxt  = TGT_CTRL;
            port_nxt = in_address[0];
          end
        end
        ACT_READ: begin
          tgt_nxt      = rdec.target;
          rdata_nxt    = rdec.data;
          from_ram_nxt = rdec.from_ram;
          port_nxt     = rdec.port;
          ram_re       = rdec.from_ram;
        end
        ACT_TICK: begin
          if (tick_phase_r == PHASE_EVEN_SLOT || tick_phase_r == PHASE_ODD_SLOT) begin
            if (dma_active_r) begin
              if (dma_align_r) begin
                if (tick_phase_r[0]) begin
                  dma_align_nxt = 1'b0;
                end
              end else if (!tick_phase_r[0]) begin
                tgt_nxt         = sdec.target;
                rdata_nxt       = sdec.data;
                from_ram_nxt    = sdec.from_ram;
                port_nxt        = sdec.port;
                ram_re          = sdec.from_ram;
                ram_ra          = src_addr[RAM_ADDR_BITS-1:0];
                dma_latched_nxt = sdec.data;
                latch_pend_nxt  = sdec.from_ram;
              end else begin
                owv_nxt        = 1'b1;
                owa_nxt        = dma_offset_r;
                owd_nxt        = dma_latched_r;
                dma_offset_nxt = dma_offset_r + 8'd1;
                dma_done_nxt   = done_inc;
                if (done_inc == 8'h00) begin
                  dma_active_nxt = 1'b0;
                  dma_align_nxt  = 1'b1;
                end
              end
            end else begin
              cen_nxt = 1'b1;
            end
          end
          tick_phase_nxt = (tick_phase_r >= PHASE_LAST) ? 3'd0 : tick_phase_r + 3'd1;
        end
        ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r  <= 1'b1;
      clr_addr_r    <= '0;
      tick_phase_r  <= 3'd0;
      dma_active_r  <= 1'b0;
      dma_align_r   <= 1'b1;
      dma_page_r    <= 8'h00;
      dma_offset_r  <= 8'h00;
      dma_done_r    <= 8'h00;
      dma_latched_r <= 8'h00;
      latch_pend_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      clr_active_r  <= clr_active_nxt;
      clr_addr_r    <= clr_addr_nxt;
      tick_phase_r  <= tick_phase_nxt;
      dma_active_r  <= dma_active_nxt;
      dma_align_r   <= dma_align_nxt;
      dma_page_r    <= dma_page_nxt;
      dma_offset_r  <= dma_offset_nxt;
      dma_done_r    <= dma_done_nxt;
      dma_latched_r <= dma_latched_nxt;
      latch_pend_r  <= latch_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tgt_r      <= tgt_nxt;
      rdata_r    <= rdata_nxt;
      from_ram_r <= from_ram_nxt;
      port_r     <= port_nxt;
      owv_r      <= owv_nxt;
      owa_r      <= owa_nxt;
      owd_r      <= owd_nxt;
      cen_r      <= cen_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_target           = tgt_r;
  assign out_read_data        = from_ram_r ? ram_q : rdata_r;
  assign out_controller_port  = port_r;
  assign out_oam_write_valid  = owv_r;
  assign out_oam_write_addr   = owa_r;
  assign out_oam_write_data   = owd_r;
  assign out_cpu_clock_enable = cen_r;
  assign out_dma_busy         = dma_active_r;
  assign out_dma_source_addr  = {dma_page_r, dma_offset_r};

  `CBD_ASSERT_IMP(a_no_request_while_clearing, clk, rst_n, clr_active_r, !in_ready)
  `CBD_ASSERT_IMP(a_cpu_step_only_when_idle, clk, rst_n, out_valid_r && cen_r, !dma_active_r)
  `CBD_ASSERT_NXT(a_oam_write_on_odd_slot, clk, rst_n, accept && owv_nxt, tick_phase_r == PHASE_ODD_SLOT + 3'd1)
  `CBD_ASSERT_IMP(a_latch_before_write, clk, rst_n, latch_pend_r, !(accept && owv_nxt))

endmodule
`default_nettype wire

// ===== sim/cpu_bus_decoder_with_oam_dma_core_checker.sv =====
module cpu_bus_decoder_with_oam_dma_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_cart_claims,
  input  logic [7:0]  in_external_read_data,
  input  logic [7:0]  in_oam_pointer,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_target,
  input  logic [7:0]  out_read_data,
  input  logic        out_controller_port,
  input  logic        out_oam_write_valid,
  input  logic [7:0]  out_oam_write_addr,
  input  logic [7:0]  out_oam_write_data,
  input  logic        out_cpu_clock_enable,
  input  logic        out_dma_busy,
  input  logic [15:0] out_dma_source_addr,
  output int          fail_count,
  output int          pending
);
  import cbdoam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    target_t     target;
    logic [7:0]  read_data;
    logic        port;
    logic        oam_we;
    logic [7:0]  oam_addr;
    logic [7:0]  oam_data;
    logic        cpu_en;
    logic        busy;
    logic [15:0] src_addr;
  } bus_result_t;

  logic [7:0] wram [RAM_DEPTH];
  logic [2:0] phase;
  logic       dma_on;
  logic       align_wait;
  logic [7:0] src_page;
  logic [7:0] src_off;
  logic [7:0] moved;
  logic [7:0] latched;

  bus_result_t bus_results_q[$];
  bus_result_t want;

  function automatic target_t decode_read(input logic [15:0] addr, input logic claim,
                                          input logic [7:0] ext, output logic [7:0] data,
                                          output logic port);
    data = 8'h00;
    port = 1'b0;
    if (claim) begin
      data = ext;
      return TGT_CART;
    end
    if (addr < PPU_BASE) begin
      data = wram[addr[RAM_ADDR_BITS-1:0]];
      return TGT_RAM;
    end
    if (addr < IO_BASE) begin
      data = ext;
      return TGT_PPU;
    end
    if (addr == CTRL_PORT0 || addr == CTRL_PORT1) begin
      data = ext;
      port = addr[0];
      return TGT_CTRL;
    end
    return TGT_OPEN;
  endfunction

  function automatic bus_result_t bus_step(input logic [1:0] act, input logic [15:0] addr,
                                           input logic [7:0] wdata, input logic claim,
                                           input logic [7:0] ext, input logic [7:0] oamp);
    bus_result_t r;
    r.target    = TGT_OPEN;
    r.read_data = 8'h00;
    r.port      = 1'b0;
    r.oam_we    = 1'b0;
    r.oam_addr  = 8'h00;
    r.oam_data  = 8'h00;
    r.cpu_en    = 1'b0;
    case (action_t'(act))
      ACT_WRITE: begin
        if (claim) begin
          r.target = TGT_CART;
        end else if (addr < PPU_BASE) begin
          wram[addr[RAM_ADDR_BITS-1:0]] = wdata;
          r.target = TGT_RAM;
        end else if (addr < IO_BASE) begin
          r.target = TGT_PPU;
        end else if (addr == DMA_TRIGGER) begin
          src_page = wdata;
          src_off  = oamp;
          moved    = 8'h00;
          dma_on   = 1'b1;
          r.target = TGT_DMA;
        end else if (addr == CTRL_PORT0 || addr == CTRL_PORT1) begin
          r.target = TGT_CTRL;
          r.port   = addr[0];
        end
      end
      ACT_READ: begin
        r.target = decode_read(addr, claim, ext, r.read_data, r.port);
      end
      ACT_TICK: begin
        if (phase == PHASE_EVEN_SLOT || phase == PHASE_ODD_SLOT) begin
          if (!dma_on) begin
            r.cpu_en = 1'b1;
          end else if (align_wait) begin
            if (phase == PHASE_ODD_SLOT) align_wait = 1'b0;
          end else if (phase == PHASE_EVEN_SLOT) begin
            r.target = decode_read({src_page, src_off}, claim, ext, r.read_data, r.port);
            latched  = r.read_data;
          end else begin
            r.oam_we   = 1'b1;
            r.oam_addr = src_off;
            r.oam_data = latched;
            src_off    = src_off + 8'd1;
            moved      = moved + 8'd1;
            if (moved == 8'h00) begin
              dma_on     = 1'b0;
              align_wait = 1'b1;
            end
          end
        end
        phase = (phase >= PHASE_LAST) ? 3'd0 : phase + 3'd1;
      end
      default: ;
    endcase
    r.busy     = dma_on;
    r.src_addr = {src_page, src_off};
    return r;
  endfunction

  function automatic void check(input string name, input logic [15:0] exp_val,
                                input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RAM_DEPTH; i++) wram[i] = 8'h00;
      phase      = 3'd0;
      dma_on     = 1'b0;
      align_wait = 1'b1;
      src_page   = 8'h00;
      src_off    = 8'h00;
      moved      = 8'h00;
      latched    = 8'h00;
      bus_results_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_results_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          fail_count++;
        end else begin
          want = bus_results_q.pop_front();
          check("target", 16'(want.target), 16'(out_target));
          check("read_data", 16'(want.read_data), 16'(out_read_data));
          check("controller_port", 16'(want.port), 16'(out_controller_port));
          check("oam_write_valid", 16'(want.oam_we), 16'(out_oam_write_valid));
          check("oam_write_addr", 16'(want.oam_addr), 16'(out_oam_write_addr));
          check("oam_write_data", 16'(want.oam_data), 16'(out_oam_write_data));
          check("cpu_clock_enable", 16'(want.cpu_en), 16'(out_cpu_clock_enable));
          check("dma_busy", 16'(want.busy), 16'(out_dma_busy));
          check("dma_source_addr", want.src_addr, out_dma_source_addr);
        end
      end
      if (in_valid && in_ready) begin
        bus_results_q.push_back(bus_step(in_action, in_address, in_write_data,
                                         in_cart_claims, in_external_read_data,
                                         in_oam_pointer));
      end
      pending <= bus_results_q.size();
    end
  end

endmodule

// ===== sim/cpu_bus_decoder_with_oam_dma_core_tb.sv =====
module cpu_bus_decoder_with_oam_dma_core_tb;
  import cbdoam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 10000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_TICK;
  logic [15:0] in_address = 16'h0000;
  logic [7:0]  in_write_data = 8'h00;
  logic        in_cart_claims = 1'b0;
  logic [7:0]  in_external_read_data = 8'h00;
  logic [7:0]  in_oam_pointer = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_target;
  logic [7:0]  out_read_data;
  logic        out_controller_port;
  logic        out_oam_write_valid;
  logic [7:0]  out_oam_write_addr;
  logic [7:0]  out_oam_write_data;
  logic        out_cpu_clock_enable;
  logic        out_dma_busy;
  logic [15:0] out_dma_source_addr;

  int fail_count;
  int pending;
  int out_seen;
  int quiet;
  bit calm;
  bit held_off;
  logic [7:0] page;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cpu_bus_decoder_with_oam_dma_core u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_action             (in_action),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .in_cart_claims        (in_cart_claims),
    .in_external_read_data (in_external_read_data),
    .in_oam_pointer        (in_oam_pointer),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_target            (out_target),
    .out_read_data         (out_read_data),
    .out_controller_port   (out_controller_port),
    .out_oam_write_valid   (out_oam_write_valid),
    .out_oam_write_addr    (out_oam_write_addr),
    .out_oam_write_data    (out_oam_write_data),
    .out_cpu_clock_enable  (out_cpu_clock_enable),
    .out_dma_busy          (out_dma_busy),
    .out_dma_source_addr   (out_dma_source_addr)
  );

  cpu_bus_decoder_with_oam_dma_core_checker u_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_action             (in_action),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .in_cart_claims        (in_cart_claims),
    .in_external_read_data (in_external_read_data),
    .in_oam_pointer        (in_oam_pointer),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_target            (out_target),
    .out_read_data         (out_read_data),
    .out_controller_port   (out_controller_port),
    .out_oam_write_valid   (out_oam_write_valid),
    .out_oam_write_addr    (out_oam_write_addr),
    .out_oam_write_data    (out_oam_write_data),
    .out_cpu_clock_enable  (out_cpu_clock_enable),
    .out_dma_busy          (out_dma_busy),
    .out_dma_source_addr   (out_dma_source_addr),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input action_t act, input logic [15:0] addr, input logic [7:0] wdata,
                       input logic claim, input logic [7:0] ext, input logic [7:0] oamp);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_action             <= act;
    in_address            <= addr;
    in_write_data         <= wdata;
    in_cart_claims        <= claim;
    in_external_read_data <= ext;
    in_oam_pointer        <= oamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_random(input bit allow_trigger, input int tick_pct);
    action_t     act;
    logic [15:0] addr;
    logic [7:0]  wdata;
    int          pick;
    pick = $urandom_range(99);
    if (pick < tick_pct) act = ACT_TICK;
    else if (pick < tick_pct + (100 - tick_pct) / 2) act = ACT_WRITE;
    else if (pick < 97) act = ACT_READ;
    else act = ACT_NONE;
    pick = $urandom_range(99);
    if (pick < 40) addr = 16'($urandom_range(16'h1FFF));
    else if (pick < 55) addr = 16'($urandom_range(16'h3FFF, PPU_BASE));
    else if (pick < 67) addr = CTRL_PORT0 + 16'($urandom_range(1));
    else if (pick < 72) addr = allow_trigger ? DMA_TRIGGER : IO_BASE + 16'($urandom_range(16'h13));
    else if (pick < 78) addr = IO_BASE + 16'($urandom_range(31));
    else addr = 16'($urandom);
    wdata = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom);
    offer(act, addr, wdata, $urandom_range(99) < 20, 8'($urandom), 8'($urandom));
  endtask

  // start a transfer and keep the bus busy long enough for all 256 bytes to move
  task automatic run_transfer(input logic [7:0] src_page);
    offer(ACT_WRITE, DMA_TRIGGER, src_page, 1'b0, 8'($urandom), 8'($urandom));
    for (int k = 0; k < 1580; k++) begin
      calm = (k >= 400 && k < 700);
      offer_random(1'b0, 99);
    end
    calm = 1'b0;
  endtask

  initial begin
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) out_seen <= out_seen + 1;
  end

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && out_seen >= 300) begin
        // long hold-off so the result register fills and the input stalls
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        held_off = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer(ACT_READ, 16'h0000, 8'h00, 1'b0, 8'hFF, 8'h00);
    offer(ACT_WRITE, 16'h07FF, 8'hFF, 1'b0, 8'h00, 8'h00);
    offer(ACT_READ, 16'h1FFF, 8'h00, 1'b0, 8'h00, 8'h00);
    offer(ACT_WRITE, 16'h0800, 8'hA5, 1'b0, 8'h00, 8'h00);
    offer(ACT_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);
    offer(ACT_WRITE, PPU_BASE, 8'h3C, 1'b0, 8'h00, 8'h00);
    offer(ACT_READ, 16'h3FFF, 8'h00, 1'b0, 8'h5A, 8'h00);
    offer(ACT_WRITE, IO_BASE, 8'h77, 1'b0, 8'h00, 8'h00);
    offer(ACT_READ, DMA_TRIGGER, 8'h00, 1'b0, 8'hFF, 8'h00);
    offer(ACT_READ, 16'hFFFF, 8'h00, 1'b1, 8'hC3, 8'h00);
    offer(ACT_WRITE, 16'hFFFF, 8'h00, 1'b0, 8'hFF, 8'hFF);
    offer(ACT_WRITE, CTRL_PORT0, 8'h01, 1'b0, 8'h00, 8'h00);
    offer(ACT_READ, CTRL_PORT1, 8'h00, 1'b0, 8'h81, 8'h00);
    offer(ACT_WRITE, DMA_TRIGGER, 8'h12, 1'b1, 8'h00, 8'h00);
    offer(ACT_NONE, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    offer(ACT_TICK, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);
    offer(ACT_TICK, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);
    offer(ACT_WRITE, DMA_TRIGGER, 8'h07, 1'b0, 8'h00, 8'hFC);
    repeat (6) offer(ACT_TICK, 16'($urandom), 8'($urandom), 1'b0, 8'($urandom), 8'($urandom));
    // restart while a transfer is running
    offer(ACT_WRITE, DMA_TRIGGER, 8'h40, 1'b0, 8'h00, 8'h10);
    repeat (4) offer(ACT_TICK, 16'($urandom), 8'($urandom), 1'($urandom_range(1)),
                     8'($urandom), 8'($urandom));

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // fill part of one ram page through random mirrors, then move it to oam
    page = 8'($urandom_range(31));
    for (int i = 0; i < 32; i++) begin
      offer(ACT_WRITE, {3'b000, 2'($urandom_range(3)), page[2:0], 8'($urandom)},
            8'($urandom), 1'b0, 8'($urandom), 8'($urandom));
    end
    run_transfer(page);

    for (int k = 0; k < 80; k++) begin
      offer_random(1'b1, 55);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbdoam_pkg.sv
rtl/cbdoam_ram.sv
rtl/cpu_bus_decoder_with_oam_dma_core.sv
sim/cpu_bus_decoder_with_oam_dma_core_checker.sv
sim/cpu_bus_decoder_with_oam_dma_core_tb.sv
